FILE: src/dsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack package
// Word types and operation and status codes shared by the dual stack block.
// ----------------------------------------------------------------------------
package dsa_pkg;

    // Width of the stack size register as it appears on the configuration port.
    localparam int SIZE_W  = 9;
    localparam int VALUE_W = 32;

    // Operation codes. Any code other than push or pop acts as a peek.
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Stack selection codes.
    localparam logic SEL_LOWER = 1'b0;
    localparam logic SEL_UPPER = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic                       which_stack;
        logic signed [VALUE_W-1:0]  push_value;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic [1:0]                 status;
        logic                       lower_empty;
        logic                       upper_empty;
        logic                       shared_full;
    } out_word_t;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

endpackage

FILE: src/dsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module dsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/dual_stack_shared_array.sv
`timescale 1ns / 1ps
// A word accepted while idle has its read data registered in the slot memory, and its result
// is then loaded into the output register once that register is free. No new word is taken
// until then, but the next word is accepted while an earlier result still waits to be taken.
// Reset: both stacks empty, stack size equal to DEPTH, no result pending. The slot memory
// is not cleared; only slots written by a push are ever read.
// ----------------------------------------------------------------------------
// Two stacks in one array
// The lower stack grows upward from slot 0, the upper stack grows downward from
// the configured size. Each word performs a push, pop or peek on one stack.
// ----------------------------------------------------------------------------
module dual_stack_shared_array #(
    parameter int DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [dsa_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  dsa_pkg::in_word_t      in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output dsa_pkg::out_word_t     out_word
);

    import dsa_pkg::*;

    // Slot address width, and the width of a pointer that can also hold DEPTH itself.
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    // Width in which the raw size write is compared against DEPTH.
    localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;

    // The lower stack is kept as an entry count (its top index plus one); the upper stack
    // as the index of its top entry, equal to the size when it is empty.
    logic [CW-1:0]      lower_cnt_reg, lower_cnt_next;
    logic [CW-1:0]      upper_top_reg, upper_top_next;
    logic [CW-1:0]      size_reg, size_next;
    state_t             state_reg, state_next;

    // Result fields settled at accept time, waiting for the memory read data.
    logic [1:0]         pend_status_reg, pend_status_next;
    logic               pend_lower_empty_reg, pend_lower_empty_next;
    logic               pend_upper_empty_reg, pend_upper_empty_next;
    logic               pend_full_reg, pend_full_next;
    logic               pend_rd_reg, pend_rd_next;

    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic               in_accept;
    logic               out_free;
    logic               is_full;
    logic               lower_is_empty;
    logic               upper_is_empty;
    logic [CW-1:0]      lower_dec;
    logic [CW-1:0]      upper_dec;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    logic [CMPW-1:0]    cfg_size_wide;
    logic [CMPW-1:0]    cfg_size_clamped;

    // A new word is taken only when no earlier word is waiting for its read data. The
    // output register may still be full; the response state then holds until it drains.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign is_full        = (lower_cnt_reg == upper_top_reg);
    assign lower_is_empty = (lower_cnt_reg == '0);
    assign upper_is_empty = (upper_top_reg >= size_reg);
    assign lower_dec      = lower_cnt_reg - CW'(1);
    assign upper_dec      = upper_top_reg - CW'(1);

    // A size write of zero counts as one, and one above DEPTH counts as DEPTH.
    assign cfg_size_wide = CMPW'(cfg_wr_data);
    always_comb
    begin
        if (cfg_size_wide == '0)
        begin
            cfg_size_clamped = CMPW'(1);
        end
        else if (cfg_size_wide > CMPW'(DEPTH))
        begin
            cfg_size_clamped = CMPW'(DEPTH);
        end
        else
        begin
            cfg_size_clamped = cfg_size_wide;
        end
    end

    // Operation decode, pointer update and memory access for an accepted word.
    always_comb
    begin
        lower_cnt_next        = lower_cnt_reg;
        upper_top_next        = upper_top_reg;
        size_next             = size_reg;
        pend_status_next      = pend_status_reg;
        pend_lower_empty_next = pend_lower_empty_reg;
        pend_upper_empty_next = pend_upper_empty_reg;
        pend_full_next        = pend_full_reg;
        pend_rd_next          = pend_rd_reg;
        ram_wr_en             = 1'b0;
        ram_wr_addr           = lower_cnt_reg[AW-1:0];
        ram_rd_en             = 1'b0;
        ram_rd_addr           = lower_dec[AW-1:0];

        if (cfg_wr_en)
        begin
            // Size write empties both stacks; user must write only while idle, unenforced.
            size_next      = CW'(cfg_size_clamped);
            lower_cnt_next = '0;
            upper_top_next = CW'(cfg_size_clamped);
        end
        else if (in_accept)
        begin
            pend_status_next = STATUS_OK;
            pend_rd_next     = 1'b0;
            if (in_word.mode == MODE_PUSH)
            begin
                if (is_full)
                begin
                    pend_status_next = STATUS_FULL;
                end
                else if (in_word.which_stack == SEL_LOWER)
                begin
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = lower_cnt_reg[AW-1:0];
                    lower_cnt_next = lower_cnt_reg + CW'(1);
                end
                else
                begin
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = upper_dec[AW-1:0];
                    upper_top_next = upper_dec;
                end
            end
            else if (in_word.which_stack == SEL_LOWER)
            begin
                if (lower_is_empty)
                begin
                    pend_status_next = STATUS_EMPTY;
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = lower_dec[AW-1:0];
                    pend_rd_next = 1'b1;
                    if (in_word.mode == MODE_POP)
                    begin
                        lower_cnt_next = lower_dec;
                    end
                end
            end
            else
            begin
                if (upper_is_empty)
                begin
                    pend_status_next = STATUS_EMPTY;
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = upper_top_reg[AW-1:0];
                    pend_rd_next = 1'b1;
                    if (in_word.mode == MODE_POP)
                    begin
                        upper_top_next = upper_top_reg + CW'(1);
                    end
                end
            end
            // Flags describe the stacks after this word.
            pend_lower_empty_next = (lower_cnt_next == '0);
            pend_upper_empty_next = (upper_top_next >= size_reg);
            pend_full_next        = (lower_cnt_next == upper_top_next);
        end
    end

    // Sequencer and output register. The response state waits for a free output
    // register; the memory read data holds meanwhile since no new read is issued.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.read_value  = pend_rd_reg ? ram_rd_data : '1;
                    out_word_next.status      = pend_status_reg;
                    out_word_next.lower_empty = pend_lower_empty_reg;
                    out_word_next.upper_empty = pend_upper_empty_reg;
                    out_word_next.shared_full = pend_full_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            size_reg      <= CW'(DEPTH);
            lower_cnt_reg <= '0;
            upper_top_reg <= CW'(DEPTH);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            size_reg      <= size_next;
            lower_cnt_reg <= lower_cnt_next;
            upper_top_reg <= upper_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg      <= pend_status_next;
        pend_lower_empty_reg <= pend_lower_empty_next;
        pend_upper_empty_reg <= pend_upper_empty_next;
        pend_full_reg        <= pend_full_next;
        pend_rd_reg          <= pend_rd_next;
        out_word_reg         <= out_word_next;
    end

    dsa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_word.push_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The two tops never cross, and the upper top never passes the size.
    a_tops_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lower_cnt_reg <= upper_top_reg)
        else $error("lower stack count passed upper top");

    a_upper_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        upper_top_reg <= size_reg)
        else $error("upper top beyond stack size");

    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        (size_reg != '0) && (size_reg <= CW'(DEPTH)))
        else $error("stack size out of range");

    a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_RESP))
        else $error("accepted word did not enter response state");

    a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) && out_free |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("response not delivered to output register");

endmodule
